### src/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// shared types and constants of the k-way merge with equal-value cohorts
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SIDX_W = 4;
  localparam int unsigned CFG_W  = 5;
  localparam int unsigned DEF_STREAMS = 16;

  localparam logic signed [VAL_W-1:0] I32MAX = 32'sh7fff_ffff;

  typedef enum logic [16:0] {
    ST_SWEEP   = 17'h00001,
    ST_PRE     = 17'h00002,
    ST_IDLE    = 17'h00004,
    ST_CHK     = 17'h00008,
    ST_HS      = 17'h00010,
    ST_VAL     = 17'h00020,
    ST_ROOT    = 17'h00040,
    ST_ROOTCHK = 17'h00080,
    ST_ROOTV   = 17'h00100,
    ST_CDOWN   = 17'h00200,
    ST_CRD     = 17'h00400,
    ST_CWR     = 17'h00800,
    ST_CUP     = 17'h01000,
    ST_ORD     = 17'h02000,
    ST_OLD     = 17'h04000,
    ST_OWAIT   = 17'h08000,
    ST_FIN     = 17'h10000
  } state_e;

endpackage

### src/kwm_in_if.sv
// ----------------------------------------------------------------------------
// kwm_in_if
// input channel: next value or exhaustion of the pending stream
// ----------------------------------------------------------------------------
interface kwm_in_if;
  logic                               valid;
  logic                               ready;
  logic                               has_value;
  logic signed [kwm_pkg::VAL_W-1:0]   value;

  modport source (output valid, output has_value, output value, input ready);
  modport sink   (input valid, input has_value, input value, output ready);
endinterface

### src/kwm_out_if.sv
// ----------------------------------------------------------------------------
// kwm_out_if
// output channel: one cohort member or the done word
// ----------------------------------------------------------------------------
interface kwm_out_if;
  logic                              valid;
  logic                              ready;
  logic [kwm_pkg::SIDX_W-1:0]        stream_index;
  logic signed [kwm_pkg::VAL_W-1:0]  min_value;
  logic                              last_in_cohort;
  logic                              done_res;

  modport source (output valid, output stream_index, output min_value,
                  output last_in_cohort, output done_res, input ready);
  modport sink   (input valid, input stream_index, input min_value,
                  input last_in_cohort, input done_res, output ready);
endinterface

### src/kwm_ram.sv
// ----------------------------------------------------------------------------
// kwm_ram
// one write port, two registered read ports
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int unsigned W  = 8,
  parameter int unsigned D  = 17,
  parameter int unsigned AW = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [W-1:0]  rdata_a_o,
  output logic [W-1:0]  rdata_b_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

### src/kway_merge_equal_cohorts.sv
// ----------------------------------------------------------------------------
// kway_merge_equal_cohorts
// min-heap merge of sorted streams, reporting every stream tied at the minimum
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_i      in    valid/ready      has_value, value
//  out_o     out   valid/ready      stream_index, min_value, last_in_cohort,
//                                   done_res
//  cfg       in    cfg_we_i         cfg_wdata_i (stream count)
//
//  each word sifts down the heap one level at a time, each level taking a child
//  slot read, a child value read and a compare.
//  a completing word adds a root read, a post-order walk over the tied nodes
//  and the result words; the heap and value memories have one write port.
//  after reset or a stream-count write a fill pass over all MAX_STREAMS + 1
//  heap slots runs with in_i.ready low; a stalled output holds the whole block.
// ----------------------------------------------------------------------------
module kway_merge_equal_cohorts #(
  parameter int unsigned MAX_STREAMS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  kwm_in_if.sink                      in_i,
  kwm_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [kwm_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int unsigned NW    = $clog2(MAX_STREAMS + 1);
  localparam int unsigned LW    = NW + 1;
  localparam int unsigned DEPTH = MAX_STREAMS + 1;
  localparam int unsigned PW    = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int unsigned SXW   = (NW > kwm_pkg::CFG_W) ? NW : kwm_pkg::CFG_W;
  localparam int unsigned VW    = kwm_pkg::VAL_W;
  localparam int unsigned XW    = kwm_pkg::SIDX_W;

  kwm_pkg::state_e st_q, st_d;

  logic [NW-1:0]  n_q, n_d;
  logic [NW-1:0]  c_q, c_d;
  logic [NW-1:0]  s_q, s_d;
  logic [NW-1:0]  hl_q, hl_d, hr_q, hr_d;
  logic [NW-1:0]  sw_q, sw_d;
  logic [NW-1:0]  pos_q, pos_d, cnt_q, cnt_d, len_q, len_d, oi_q, oi_d;
  logic signed [VW-1:0] x_q, x_d, mv_q, mv_d;
  logic [DEPTH-1:0] eql_q, eql_d, eqr_q, eqr_d;

  logic           ov_q, ov_d;
  logic [XW-1:0]  os_q, os_d;
  logic signed [VW-1:0] om_q, om_d;
  logic           ol_q, ol_d, od_q, od_d;

  // heap slot memory
  logic           hs_we;
  logic [NW-1:0]  hs_wa, hs_wd, hs_ra, hs_rb, hs_rda, hs_rdb;
  // stream value memory
  logic           vm_we;
  logic [NW-1:0]  vm_wa, vm_ra, vm_rb;
  logic [VW-1:0]  vm_wd, vm_rda, vm_rdb;

  // pending list memory
  logic [NW-1:0]  pn_mem [MAX_STREAMS];
  logic [XW-1:0]  ps_mem [MAX_STREAMS];
  logic           pm_we;
  logic [PW-1:0]  pm_wa, pm_ra;
  logic [NW-1:0]  pm_wn, pn_rd;
  logic [XW-1:0]  pm_ws, ps_rd;

  kwm_ram #(.W(NW), .D(DEPTH), .AW(NW)) u_hs_ram (
    .clk_i, .we_i(hs_we), .waddr_i(hs_wa), .wdata_i(hs_wd),
    .raddr_a_i(hs_ra), .raddr_b_i(hs_rb), .rdata_a_o(hs_rda), .rdata_b_o(hs_rdb)
  );

  kwm_ram #(.W(VW), .D(DEPTH), .AW(NW)) u_val_ram (
    .clk_i, .we_i(vm_we), .waddr_i(vm_wa), .wdata_i(vm_wd),
    .raddr_a_i(vm_ra), .raddr_b_i(vm_rb), .rdata_a_o(vm_rda), .rdata_b_o(vm_rdb)
  );

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pn_mem[pm_wa] <= pm_wn;
      ps_mem[pm_wa] <= pm_ws;
    end
    pn_rd <= pn_mem[pm_ra];
    ps_rd <= ps_mem[pm_ra];
  end

  // combinational helpers
  logic [LW-1:0]  n_w, l_w, c1_w;
  logic [NW-1:0]  l_idx, r_idx, p_idx;
  logic           has_kids, has_r, in_has;
  logic signed [VW-1:0] vl, vr;
  logic [SXW-1:0] s_ext, cv_ext, hsm1;
  logic [NW-1:0]  in_node, in_s, cfg_n, sw_rem;
  logic           pos_last;

  always_comb begin
    n_w      = {1'b0, n_q};
    l_w      = {c_q, 1'b0};
    c1_w     = {1'b0, c_q} + LW'(1);
    l_idx    = l_w[NW-1:0];
    r_idx    = l_idx + NW'(1);
    p_idx    = c_q >> 1;
    has_kids = (l_w <= n_w);
    has_r    = (l_w < n_w);
    vl       = $signed(vm_rda);
    vr       = $signed(vm_rdb);
    in_has   = in_i.has_value && (in_i.value != kwm_pkg::I32MAX);
    s_ext    = SXW'(ps_rd) + SXW'(1);
    in_s     = (s_ext > SXW'(n_q)) ? n_q : s_ext[NW-1:0];
    in_node  = ((pn_rd == '0) || (pn_rd > n_q)) ? NW'(1) : pn_rd;
    hsm1     = SXW'(hs_rda) - SXW'(1);
    cv_ext   = SXW'(cfg_wdata_i);
    if (cv_ext == '0) begin
      cv_ext = SXW'(1);
    end
    if (cv_ext > SXW'(MAX_STREAMS)) begin
      cv_ext = SXW'(MAX_STREAMS);
    end
    cfg_n    = cv_ext[NW-1:0];
    sw_rem   = n_q - sw_q;
    pos_last = ((pos_q + NW'(1)) >= cnt_q);
  end

  always_comb begin
    st_d = st_q;
    n_d = n_q; c_d = c_q; s_d = s_q; hl_d = hl_q; hr_d = hr_q; sw_d = sw_q;
    pos_d = pos_q; cnt_d = cnt_q; len_d = len_q; oi_d = oi_q;
    x_d = x_q; mv_d = mv_q; eql_d = eql_q; eqr_d = eqr_q;
    ov_d = ov_q; os_d = os_q; om_d = om_q; ol_d = ol_q; od_d = od_q;
    hs_we = 1'b0; hs_wa = c_q; hs_wd = s_q; hs_ra = l_idx; hs_rb = r_idx;
    vm_we = 1'b0; vm_wa = s_q; vm_wd = x_q; vm_ra = hs_rda; vm_rb = hs_rdb;
    pm_we = 1'b0; pm_wa = len_q[PW-1:0]; pm_wn = c_q; pm_ws = hsm1[XW-1:0];
    pm_ra = pos_q[PW-1:0];

    unique case (st_q)
      kwm_pkg::ST_SWEEP: begin
        hs_we = 1'b1;
        hs_wa = sw_q;
        hs_wd = ((sw_q != '0) && (sw_q <= n_q)) ? sw_q : '0;
        vm_we = 1'b1;
        vm_wa = sw_q;
        vm_wd = (sw_q == '0) ? kwm_pkg::I32MAX : '0;
        if (sw_q < NW'(MAX_STREAMS)) begin
          pm_we = 1'b1;
          pm_wa = sw_q[PW-1:0];
          pm_wn = (sw_q < n_q) ? sw_rem : '0;
          pm_ws = (sw_q < n_q) ? XW'(sw_rem - NW'(1)) : '0;
        end
        if (sw_q == NW'(MAX_STREAMS)) begin
          pos_d = '0;
          cnt_d = n_q;
          st_d  = kwm_pkg::ST_PRE;
        end else begin
          sw_d = sw_q + NW'(1);
        end
      end
      kwm_pkg::ST_PRE: begin
        pm_ra = pos_q[PW-1:0];
        st_d  = kwm_pkg::ST_IDLE;
      end
      kwm_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          x_d   = in_has ? in_i.value : kwm_pkg::I32MAX;
          s_d   = in_has ? in_s : '0;
          c_d   = in_node;
          vm_we = 1'b1;
          vm_wa = in_has ? in_s : '0;
          vm_wd = in_has ? in_i.value : kwm_pkg::I32MAX;
          st_d  = kwm_pkg::ST_CHK;
        end
      end
      kwm_pkg::ST_CHK: begin
        if (!has_kids) begin
          hs_we = 1'b1;
          eql_d[c_q] = 1'b0;
          eqr_d[c_q] = 1'b0;
          if (pos_last) begin
            pos_d = '0;
            st_d  = kwm_pkg::ST_ROOT;
          end else begin
            pos_d = pos_q + NW'(1);
            st_d  = kwm_pkg::ST_PRE;
          end
        end else begin
          st_d = kwm_pkg::ST_HS;
        end
      end
      kwm_pkg::ST_HS: begin
        hl_d  = hs_rda;
        hr_d  = has_r ? hs_rdb : '0;
        vm_ra = hs_rda;
        vm_rb = has_r ? hs_rdb : '0;
        st_d  = kwm_pkg::ST_VAL;
      end
      kwm_pkg::ST_VAL: begin
        hs_we = 1'b1;
        priority if (vl < vr) begin
          eqr_d[c_q] = 1'b0;
          if (x_q > vl) begin
            hs_wd = hl_q;
            eql_d[c_q] = eql_q[l_idx] | eqr_q[l_idx];
            c_d = l_idx;
          end else begin
            eql_d[c_q] = (x_q == vl);
          end
        end else if (vr < vl) begin
          eql_d[c_q] = 1'b0;
          if (x_q > vr) begin
            hs_wd = hr_q;
            eqr_d[c_q] = eql_q[r_idx] | eqr_q[r_idx];
            c_d = r_idx;
          end else begin
            eqr_d[c_q] = (x_q == vr);
          end
        end else begin
          if (x_q > vl) begin
            hs_wd = hl_q;
            eql_d[c_q] = eql_q[l_idx] | eqr_q[l_idx];
            eqr_d[c_q] = 1'b1;
            c_d = l_idx;
          end else begin
            eql_d[c_q] = (x_q == vl);
            eqr_d[c_q] = (x_q == vl);
          end
        end
        if (((vl <= vr) && (x_q > vl)) || ((vr < vl) && (x_q > vr))) begin
          st_d = kwm_pkg::ST_CHK;
        end else if (pos_last) begin
          pos_d = '0;
          st_d  = kwm_pkg::ST_ROOT;
        end else begin
          pos_d = pos_q + NW'(1);
          st_d  = kwm_pkg::ST_PRE;
        end
      end
      kwm_pkg::ST_ROOT: begin
        hs_ra = NW'(1);
        st_d  = kwm_pkg::ST_ROOTCHK;
      end
      kwm_pkg::ST_ROOTCHK: begin
        vm_ra = hs_rda;
        if (hs_rda == '0) begin
          ov_d = 1'b1;
          os_d = '0;
          om_d = '0;
          ol_d = 1'b0;
          od_d = 1'b1;
          st_d = kwm_pkg::ST_OWAIT;
        end else begin
          st_d = kwm_pkg::ST_ROOTV;
        end
      end
      kwm_pkg::ST_ROOTV: begin
        mv_d  = vl;
        c_d   = NW'(1);
        len_d = '0;
        st_d  = kwm_pkg::ST_CDOWN;
      end
      kwm_pkg::ST_CDOWN: begin
        priority if (eql_q[c_q] && (l_w <= n_w)) begin
          c_d = l_idx;
        end else if (eqr_q[c_q] && ((l_w + LW'(1)) <= n_w)) begin
          c_d = r_idx;
        end else begin
          st_d = kwm_pkg::ST_CRD;
        end
      end
      kwm_pkg::ST_CRD: begin
        hs_ra = c_q;
        st_d  = kwm_pkg::ST_CWR;
      end
      kwm_pkg::ST_CWR: begin
        if (len_q < NW'(MAX_STREAMS)) begin
          pm_we = 1'b1;
          len_d = len_q + NW'(1);
        end
        st_d = kwm_pkg::ST_CUP;
      end
      kwm_pkg::ST_CUP: begin
        if (c_q == NW'(1)) begin
          cnt_d = len_q;
          oi_d  = '0;
          st_d  = kwm_pkg::ST_ORD;
        end else if (!c_q[0] && eqr_q[p_idx] && (c1_w <= n_w)) begin
          c_d  = c1_w[NW-1:0];
          st_d = kwm_pkg::ST_CDOWN;
        end else begin
          c_d  = p_idx;
          st_d = kwm_pkg::ST_CRD;
        end
      end
      kwm_pkg::ST_ORD: begin
        pm_ra = oi_q[PW-1:0];
        st_d  = kwm_pkg::ST_OLD;
      end
      kwm_pkg::ST_OLD: begin
        ov_d = 1'b1;
        os_d = ps_rd;
        om_d = mv_q;
        ol_d = ((oi_q + NW'(1)) == cnt_q);
        od_d = 1'b0;
        st_d = kwm_pkg::ST_OWAIT;
      end
      kwm_pkg::ST_OWAIT: begin
        if (out_o.ready) begin
          ov_d = 1'b0;
          if (od_q) begin
            st_d = kwm_pkg::ST_FIN;
          end else if (ol_q) begin
            pos_d = '0;
            st_d  = kwm_pkg::ST_PRE;
          end else begin
            oi_d = oi_q + NW'(1);
            st_d = kwm_pkg::ST_ORD;
          end
        end
      end
      kwm_pkg::ST_FIN: begin
        st_d = kwm_pkg::ST_FIN;
      end
      default: begin
        st_d = kwm_pkg::ST_SWEEP;
      end
    endcase

    // stream count write restarts the merge
    if (cfg_we_i) begin
      n_d   = cfg_n;
      sw_d  = '0;
      eql_d = '0;
      eqr_d = '0;
      ov_d  = 1'b0;
      st_d  = kwm_pkg::ST_SWEEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= kwm_pkg::ST_SWEEP;
      n_q   <= NW'((MAX_STREAMS < kwm_pkg::DEF_STREAMS) ? MAX_STREAMS
                                                         : kwm_pkg::DEF_STREAMS);
      sw_q  <= '0;
      pos_q <= '0;
      cnt_q <= '0;
      len_q <= '0;
      oi_q  <= '0;
      eql_q <= '0;
      eqr_q <= '0;
      ov_q  <= 1'b0;
      od_q  <= 1'b0;
      ol_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      n_q   <= n_d;
      sw_q  <= sw_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      len_q <= len_d;
      oi_q  <= oi_d;
      eql_q <= eql_d;
      eqr_q <= eqr_d;
      ov_q  <= ov_d;
      od_q  <= od_d;
      ol_q  <= ol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q  <= c_d;
    s_q  <= s_d;
    hl_q <= hl_d;
    hr_q <= hr_d;
    x_q  <= x_d;
    mv_q <= mv_d;
    os_q <= os_d;
    om_q <= om_d;
  end

  assign in_i.ready           = (st_q == kwm_pkg::ST_IDLE) || (st_q == kwm_pkg::ST_FIN);
  assign out_o.valid          = ov_q;
  assign out_o.stream_index   = os_q;
  assign out_o.min_value      = om_q;
  assign out_o.last_in_cohort = ol_q;
  assign out_o.done_res       = od_q;

endmodule

### sim/tb_kway_merge_equal_cohorts.sv
// ----------------------------------------------------------------------------
// tb_kway_merge_equal_cohorts
// drives sorted streams into the k-way merge, predicts every cohort word and
// the done word with an own heap model, and checks the output word by word
// under random gaps on both channels and several stream counts
// ----------------------------------------------------------------------------
module tb_kway_merge_equal_cohorts;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSTR = 16;
  localparam int unsigned WDOG_LIMIT = 6000;
  localparam int unsigned SETTLE = 80;

  typedef struct {
    logic [kwm_pkg::SIDX_W-1:0]       sidx;
    logic signed [kwm_pkg::VAL_W-1:0] minv;
    logic                             last;
    logic                             done;
  } cohort_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [kwm_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  kwm_in_if  in_ch ();
  kwm_out_if out_ch ();

  kway_merge_equal_cohorts #(.MAX_STREAMS(NSTR)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // heap model state
  int unsigned n_act;
  int unsigned heap_of[NSTR+1];
  logic signed [kwm_pkg::VAL_W-1:0] val_of[NSTR+1];
  bit eq_l[NSTR+1], eq_r[NSTR+1];
  int unsigned pend_node[NSTR], pend_strm[NSTR];
  int unsigned pend_cnt, pend_pos;
  bit merge_done;

  cohort_word_t cohort_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;

  // stimulus state per stream
  logic signed [kwm_pkg::VAL_W-1:0] last_val[NSTR];
  bit started[NSTR];
  int unsigned budget[NSTR];
  bit no_gaps = 1'b0;
  int unsigned max_budget = 3;
  bit extreme_mode = 1'b0;

  function automatic void restart_merge();
    for (int k = 0; k <= NSTR; k++) begin
      heap_of[k] = 0; val_of[k] = '0; eq_l[k] = 0; eq_r[k] = 0;
    end
    for (int k = 0; k < NSTR; k++) begin
      pend_node[k] = 0; pend_strm[k] = 0;
    end
    val_of[0] = kwm_pkg::I32MAX;
    for (int k = 0; k < n_act; k++) begin
      heap_of[k+1] = k + 1;
      pend_node[k] = n_act - k;
      pend_strm[k] = n_act - k - 1;
    end
    pend_cnt = n_act;
    pend_pos = 0;
    merge_done = 0;
  endfunction

  function automatic void set_stream_count(logic [kwm_pkg::CFG_W-1:0] w);
    int unsigned v;
    v = 32'(w);
    if (v < 1) v = 1;
    if (v > NSTR) v = NSTR;
    n_act = v;
    restart_merge();
  endfunction

  function automatic void sift(int unsigned start, logic signed [kwm_pkg::VAL_W-1:0] x,
                               int unsigned s);
    int unsigned c, l, r, hl, hr;
    logic signed [kwm_pkg::VAL_W-1:0] vl, vr;
    c = start;
    val_of[s] = x;
    while (2 * c <= n_act) begin
      l = 2 * c; r = l + 1;
      hl = heap_of[l]; hr = 0;
      vl = val_of[hl]; vr = kwm_pkg::I32MAX;
      if (l < n_act) begin
        hr = heap_of[r]; vr = val_of[hr];
      end
      if (vl < vr) begin
        eq_r[c] = 0;
        if (x > vl) begin
          heap_of[c] = hl; eq_l[c] = eq_l[l] || eq_r[l]; c = l;
        end else begin
          heap_of[c] = s; eq_l[c] = (x == vl); return;
        end
      end else if (vr < vl) begin
        eq_l[c] = 0;
        if (x > vr) begin
          heap_of[c] = hr; eq_r[c] = eq_l[r] || eq_r[r]; c = r;
        end else begin
          heap_of[c] = s; eq_r[c] = (x == vr); return;
        end
      end else begin
        if (x > vl) begin
          heap_of[c] = hl; eq_l[c] = eq_l[l] || eq_r[l]; eq_r[c] = 1; c = l;
        end else begin
          heap_of[c] = s; eq_l[c] = (x == vl); eq_r[c] = (x == vl); return;
        end
      end
    end
    heap_of[c] = s;
    eq_l[c] = 0; eq_r[c] = 0;
  endfunction

  function automatic int unsigned gather_tied(int unsigned c, int unsigned len);
    int unsigned n;
    n = len;
    if (eq_l[c] && 2 * c <= n_act) n = gather_tied(2 * c, n);
    if (eq_r[c] && 2 * c + 1 <= n_act) n = gather_tied(2 * c + 1, n);
    if (n < NSTR) begin
      pend_node[n] = c;
      pend_strm[n] = (heap_of[c] - 1) & 15;
      n++;
    end
    return n;
  endfunction

  function automatic int unsigned next_stream();
    int unsigned k, s;
    k = (pend_pos >= NSTR) ? 0 : pend_pos;
    s = (pend_strm[k] & 15) + 1;
    if (s > n_act) s = n_act;
    return s - 1;
  endfunction

  function automatic void merge_word(logic has, logic signed [kwm_pkg::VAL_W-1:0] v);
    int unsigned k, node, s;
    cohort_word_t w;
    if (merge_done) return;
    k = (pend_pos >= NSTR) ? 0 : pend_pos;
    node = pend_node[k];
    if (node < 1 || node > n_act) node = 1;
    s = (pend_strm[k] & 15) + 1;
    if (s > n_act) s = n_act;
    if (has && v != kwm_pkg::I32MAX) sift(node, v, s);
    else sift(node, kwm_pkg::I32MAX, 0);
    pend_pos = k + 1;
    if (pend_pos < pend_cnt) return;
    pend_pos = 0;
    if (heap_of[1] == 0) begin
      merge_done = 1;
      w.sidx = '0; w.minv = '0; w.last = 0; w.done = 1;
      cohort_q.push_back(w);
      return;
    end
    pend_cnt = gather_tied(1, 0);
    for (int i = 0; i < pend_cnt; i++) begin
      w.sidx = pend_strm[i][kwm_pkg::SIDX_W-1:0];
      w.minv = val_of[heap_of[1]];
      w.last = (i + 1 == pend_cnt);
      w.done = 0;
      cohort_q.push_back(w);
    end
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output side stalls
  int unsigned out_stall = 0;
  initial out_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      out_stall <= gap_len();
    end
  end

  // result check
  always @(posedge clk_i) begin
    cohort_word_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (cohort_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: sidx %0d min %0d last %0b done %0b",
                   out_ch.stream_index, out_ch.min_value, out_ch.last_in_cohort,
                   out_ch.done_res);
      end else begin
        e = cohort_q.pop_front();
        if (out_ch.stream_index !== e.sidx || out_ch.min_value !== e.minv ||
            out_ch.last_in_cohort !== e.last || out_ch.done_res !== e.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sidx %0d min %0d last %0b done %0b, got %0d %0d %0b %0b",
                     e.sidx, e.minv, e.last, e.done, out_ch.stream_index,
                     out_ch.min_value, out_ch.last_in_cohort, out_ch.done_res);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WDOG_LIMIT) begin
      $display("tb_kway_merge_equal_cohorts failed");
      $finish;
    end
  end

  task automatic send_word(logic has, logic signed [kwm_pkg::VAL_W-1:0] v);
    repeat (gap_len()) @(negedge clk_i);
    in_ch.valid = 1'b1;
    in_ch.has_value = has;
    in_ch.value = v;
    forever begin
      @(posedge clk_i);
      if (in_ch.ready) break;
    end
    merge_word(has, v);
    items_sent++;
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    in_ch.has_value = 1'($urandom_range(0, 1));
    in_ch.value = $urandom;
  endtask

  task automatic drain();
    wait (cohort_q.size() == 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_count(logic [kwm_pkg::CFG_W-1:0] w);
    drain();
    cfg_we_i = 1'b1;
    cfg_wdata_i = w;
    @(posedge clk_i);
    set_stream_count(w);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic signed [kwm_pkg::VAL_W-1:0] first_value();
    logic signed [kwm_pkg::VAL_W-1:0] v;
    if (extreme_mode) return ($urandom_range(0, 1)) ? 32'sh8000_0000 : 32'sd2147483646;
    v = $urandom;
    if (v > 32'sd2147480000) v = 32'sd2147480000;
    return v;
  endfunction

  // one stream word for the pending stream, mostly well-formed
  task automatic feed_next();
    int unsigned s, r;
    logic signed [kwm_pkg::VAL_W-1:0] v;
    s = next_stream();
    r = $urandom_range(0, 99);
    if (merge_done || r < 4) begin
      send_word(1'($urandom_range(0, 1)), $urandom);
    end else if (budget[s] == 0 || r < 7) begin
      budget[s] = 0;
      if (r < 6) send_word(1'b1, kwm_pkg::I32MAX);
      else send_word(1'b0, $urandom);
    end else begin
      if (!started[s]) begin
        v = first_value();
        started[s] = 1;
      end else begin
        v = last_val[s];
        if ($urandom_range(0, 1) && v < 32'sd2147483644)
          v = v + $urandom_range(1, 2);
      end
      last_val[s] = v;
      budget[s]--;
      send_word(1'b1, v);
    end
  endtask

  task automatic run_merge(int unsigned extra);
    for (int k = 0; k < NSTR; k++) begin
      started[k] = 0;
      budget[k] = $urandom_range(1, max_budget);
    end
    while (!merge_done) feed_next();
    repeat (extra) feed_next();
  endtask

  task automatic test_default_count();
    max_budget = 1;
    run_merge(1);
  endtask

  task automatic test_single_stream();
    write_count(5'd0);
    max_budget = 4;
    run_merge(2);
  endtask

  task automatic test_extreme_values();
    write_count(5'd2);
    extreme_mode = 1;
    max_budget = 3;
    run_merge(0);
    extreme_mode = 0;
  endtask

  task automatic test_overrange_count();
    write_count(5'd31);
    no_gaps = 1;
    max_budget = 2;
    run_merge(0);
    no_gaps = 0;
  endtask

  task automatic test_random_merges();
    logic [kwm_pkg::CFG_W-1:0] w;
    while (items_sent < 330) begin
      w = kwm_pkg::CFG_W'($urandom_range(1, 16));
      if ($urandom_range(0, 5) == 0) w = 5'd16;
      write_count(w);
      max_budget = $urandom_range(2, 5);
      for (int k = 0; k < NSTR; k++) begin
        started[k] = 0;
        budget[k] = $urandom_range(1, max_budget);
      end
      while (!merge_done) begin
        feed_next();
        if ($urandom_range(0, 40) == 0) begin
          wait (cohort_q.size() == 0);
          @(negedge clk_i);
        end
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.has_value = 1'b0;
    in_ch.value = '0;
    set_stream_count(kwm_pkg::CFG_W'(kwm_pkg::DEF_STREAMS));
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_default_count();
    test_single_stream();
    test_extreme_values();
    test_overrange_count();
    test_random_merges();
    drain();
    if (mismatches == 0 && cohort_q.size() == 0) begin
      $display("tb_kway_merge_equal_cohorts passed");
    end else begin
      $display("tb_kway_merge_equal_cohorts failed");
    end
    $finish;
  end
endmodule
